FILE: rtl/atatfs_pkg.sv
// Shared types and constants for the ATA task-file command sequencer.
// Used by atatfs_chs and ata_taskfile_command_sequencer; depends on nothing.

package atatfs_pkg;

	// Default drive geometry for CHS addressing
	localparam int SECTORS_PER_TRACK_DEF = 63;
	localparam int HEADS_DEF             = 16;

	// Address width handled by the CHS divider (LBA28 range)
	localparam int LBA28_W = 28;

	// Task-file register selects
	localparam logic [3:0] PORT_CONTROL     = 4'd0;
	localparam logic [3:0] PORT_SECCOUNT    = 4'd1;
	localparam logic [3:0] PORT_LBA0        = 4'd2;
	localparam logic [3:0] PORT_LBA1        = 4'd3;
	localparam logic [3:0] PORT_LBA2        = 4'd4;
	localparam logic [3:0] PORT_DEVSEL      = 4'd5;
	localparam logic [3:0] PORT_COMMAND     = 4'd6;
	localparam logic [3:0] PORT_SECCOUNT_HI = 4'd7;
	localparam logic [3:0] PORT_LBA3        = 4'd8;
	localparam logic [3:0] PORT_LBA4        = 4'd9;
	localparam logic [3:0] PORT_LBA5        = 4'd10;

	// Addressing modes
	localparam logic [1:0] MODE_CHS   = 2'd0;
	localparam logic [1:0] MODE_LBA28 = 2'd1;
	localparam logic [1:0] MODE_LBA48 = 2'd2;

	// Command opcodes and fixed register bytes
	localparam logic [7:0] CMD_READ       = 8'h20;
	localparam logic [7:0] CMD_WRITE      = 8'h30;
	localparam logic [7:0] CMD_READ_EXT   = 8'h24;
	localparam logic [7:0] CMD_WRITE_EXT  = 8'h34;
	localparam logic [7:0] DEVSEL_CHS     = 8'hA0;
	localparam logic [7:0] DEVSEL_LBA     = 8'hE0;
	localparam logic [7:0] CTRL_HOB       = 8'h80;

	// Sequence lengths, as index of the final beat
	localparam logic [4:0] LAST_BEAT_SHORT = 5'd5;
	localparam logic [4:0] LAST_BEAT_LBA48 = 5'd17;
	// Offset that maps a short sequence onto the tail of the LBA48 one
	localparam logic [4:0] SHORT_SKIP      = 5'd12;

	// Incoming request
	typedef struct packed {
		logic [31:0] lba;
		logic [7:0]  sector_count;
		logic        is_write;
		logic        drive_is_slave;
		logic        supports_lba;
	} req_t;

	// Request with its CHS geometry worked out
	typedef struct packed {
		req_t        req;
		logic [7:0]  sector;
		logic [3:0]  head;
		logic [15:0] cylinder;
	} chs_req_t;

	// Register bytes for one command sequence
	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] devsel;
		logic [7:0] count;
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [7:0] b3;
		logic [7:0] cmd;
	} cmd_set_t;

endpackage

FILE: rtl/atatfs_chs.sv
// Request input register and CHS geometry pipeline (lba -> sector, head, cylinder).
// Divides by constants with reciprocal multiplies; uses atatfs_pkg.

module atatfs_chs #(
	parameter int SECTORS_PER_TRACK = atatfs_pkg::SECTORS_PER_TRACK_DEF,
	parameter int HEADS             = atatfs_pkg::HEADS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  atatfs_pkg::req_t      in_req,
	output logic                  out_valid,
	input  logic                  out_ready,
	output atatfs_pkg::chs_req_t  out_req
);

	localparam int NW = atatfs_pkg::LBA28_W;
	localparam int RW = NW + 1;

	// floor(2^NW / d): the quotient estimate is low by at most one
	localparam logic [RW-1:0] SPT_RECIP   = RW'((64'd1 << NW) / SECTORS_PER_TRACK);
	localparam logic [RW-1:0] HEADS_RECIP = RW'((64'd1 << NW) / HEADS);
	localparam logic [NW-1:0] SPT_W       = NW'(SECTORS_PER_TRACK);
	localparam logic [NW-1:0] HEADS_W     = NW'(HEADS);

	atatfs_pkg::req_t req_s1, req_s2, req_s3, req_s4;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	logic [NW-1:0] q1_s2, track_s3, q2_s4, track_s4;
	logic [7:0]    sect_s3, sect_s4;

	logic [NW+RW-1:0] prod1, prod2;
	logic [NW-1:0]    q1e, qd1, diff1, rem1;
	logic             fix1;
	logic [NW-1:0]    q2e, qd2, diff2, rem2;
	logic             fix2;

	assign rdy5     = !v_s5 || out_ready;
	assign rdy4     = !v_s4 || rdy5;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;
	assign out_valid = v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	// Stage 2: track estimate
	assign prod1 = {{RW{1'b0}}, req_s1.lba[NW-1:0]} * {{NW{1'b0}}, SPT_RECIP};
	assign q1e   = prod1[2*NW-1:NW];

	// Stage 3: remainder and correction by one
	assign qd1   = NW'({{NW{1'b0}}, q1_s2} * {{NW{1'b0}}, SPT_W});
	assign diff1 = req_s2.lba[NW-1:0] - qd1;
	assign fix1  = diff1 >= SPT_W;
	assign rem1  = fix1 ? diff1 - SPT_W : diff1;

	// Stage 4: cylinder estimate
	assign prod2 = {{RW{1'b0}}, track_s3} * {{NW{1'b0}}, HEADS_RECIP};
	assign q2e   = prod2[2*NW-1:NW];

	// Stage 5: head and cylinder
	assign qd2   = NW'({{NW{1'b0}}, q2_s4} * {{NW{1'b0}}, HEADS_W});
	assign diff2 = track_s4 - qd2;
	assign fix2  = diff2 >= HEADS_W;
	assign rem2  = fix2 ? diff2 - HEADS_W : diff2;

	always_ff @(posedge clk) begin
		if (rdy1) req_s1 <= in_req;
		if (rdy2) begin
			req_s2 <= req_s1;
			q1_s2  <= q1e;
		end
		if (rdy3) begin
			req_s3   <= req_s2;
			track_s3 <= q1_s2 + NW'(fix1);
			sect_s3  <= 8'(rem1) + 8'd1;
		end
		if (rdy4) begin
			req_s4   <= req_s3;
			track_s4 <= track_s3;
			q2_s4    <= q2e;
			sect_s4  <= sect_s3;
		end
		if (rdy5) begin
			out_req.req      <= req_s4;
			out_req.sector   <= sect_s4;
			out_req.head     <= 4'(rem2);
			out_req.cylinder <= 16'(q2_s4 + NW'(fix2));
		end
	end

endmodule

FILE: rtl/ata_taskfile_command_sequencer.sv
// Top level of the ATA task-file command sequencer: request in, register writes out.
// Instantiates atatfs_chs; uses atatfs_pkg.
//
// Channel  Dir  Handshake         Payload
// s_*      in   s_tvalid/tready   tdata: lba, sector_count, is_write, drive_is_slave, supports_lba
// m_*      out  m_tvalid/tready   tdata: write_data; tuser: port_select, addr_mode; tlast: last
// cfg_*    in   cfg_we            cfg_wdata: irq_disable
//
// A request yields 6 register writes (CHS, LBA28) or 18 (LBA48), one per cycle
// while m_tready does not stall; the next request is taken into the sequencer in
// the cycle its predecessor's command write leaves the sequencer.
// From acceptance to the first write a request passes five geometry stages, the
// sequencer and the output register. Reset is asynchronous and clears all valid
// state and irq_disable. A stall on m_tready holds the output register and backs
// up through the sequencer and geometry stages to s_tready.

module ata_taskfile_command_sequencer #(
	parameter int SECTORS_PER_TRACK = atatfs_pkg::SECTORS_PER_TRACK_DEF,
	parameter int HEADS             = atatfs_pkg::HEADS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // lba[31:0], sector_count[39:32], is_write[40],
	                               // drive_is_slave[41], supports_lba[42], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // write_data[7:0]
	output logic [5:0]  m_tuser,   // port_select[3:0], addr_mode[5:4]
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic        cfg_wdata
);

	atatfs_pkg::req_t     in_req;
	atatfs_pkg::chs_req_t f_req;
	atatfs_pkg::cmd_set_t nxt_set, cur_q;
	logic f_valid, f_ready;

	logic       irq_q;
	logic       cur_v_q;
	logic [4:0] step_q;
	logic [4:0] beat;
	logic       out_free, emit, last_beat;
	logic [3:0] port;
	logic [7:0] data;
	logic [7:0] nien;

	logic       mode48, mode28;
	logic [3:0] head;

	assign in_req.lba            = s_tdata[31:0];
	assign in_req.sector_count   = s_tdata[39:32];
	assign in_req.is_write       = s_tdata[40];
	assign in_req.drive_is_slave = s_tdata[41];
	assign in_req.supports_lba   = s_tdata[42];

	atatfs_chs #(
		.SECTORS_PER_TRACK(SECTORS_PER_TRACK),
		.HEADS(HEADS)
	) u_chs (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.in_req(in_req),
		.out_valid(f_valid),
		.out_ready(f_ready),
		.out_req(f_req)
	);

	// Build the register bytes for the request leaving the geometry pipeline
	always_comb begin
		mode48 = |f_req.req.lba[31:28];
		mode28 = !mode48 && f_req.req.supports_lba;
		nxt_set.count = f_req.req.sector_count;
		if (mode48 || mode28) begin
			nxt_set.mode = mode48 ? atatfs_pkg::MODE_LBA48 : atatfs_pkg::MODE_LBA28;
			nxt_set.b0   = f_req.req.lba[7:0];
			nxt_set.b1   = f_req.req.lba[15:8];
			nxt_set.b2   = f_req.req.lba[23:16];
			nxt_set.b3   = mode48 ? f_req.req.lba[31:24] : 8'd0;
			head         = mode48 ? 4'd0 : f_req.req.lba[27:24];
		end else begin
			nxt_set.mode = atatfs_pkg::MODE_CHS;
			nxt_set.b0   = f_req.sector;
			nxt_set.b1   = f_req.cylinder[7:0];
			nxt_set.b2   = f_req.cylinder[15:8];
			nxt_set.b3   = 8'd0;
			head         = f_req.head;
		end
		nxt_set.devsel = ((mode48 || mode28) ? atatfs_pkg::DEVSEL_LBA : atatfs_pkg::DEVSEL_CHS)
			| {3'd0, f_req.req.drive_is_slave, head};
		if (mode48)
			nxt_set.cmd = f_req.req.is_write ? atatfs_pkg::CMD_WRITE_EXT
			                                 : atatfs_pkg::CMD_READ_EXT;
		else
			nxt_set.cmd = f_req.req.is_write ? atatfs_pkg::CMD_WRITE : atatfs_pkg::CMD_READ;
	end

	assign out_free  = !m_tvalid || m_tready;
	assign emit      = cur_v_q && out_free;
	assign last_beat = step_q == ((cur_q.mode == atatfs_pkg::MODE_LBA48)
		? atatfs_pkg::LAST_BEAT_LBA48 : atatfs_pkg::LAST_BEAT_SHORT);
	assign f_ready   = !cur_v_q || (emit && last_beat);

	// Short sequences skip the high-order block: map onto the LBA48 beat numbering
	assign beat = (cur_q.mode == atatfs_pkg::MODE_LBA48 || step_q == 5'd0)
		? step_q : step_q + atatfs_pkg::SHORT_SKIP;

	assign nien = {6'd0, irq_q, 1'b0};

	always_comb begin
		case (beat)
			5'd0: begin
				port = atatfs_pkg::PORT_DEVSEL;
				data = cur_q.devsel;
			end
			5'd1, 5'd4, 5'd7, 5'd10: begin
				port = atatfs_pkg::PORT_CONTROL;
				data = atatfs_pkg::CTRL_HOB | nien;
			end
			5'd3, 5'd6, 5'd9, 5'd12: begin
				port = atatfs_pkg::PORT_CONTROL;
				data = nien;
			end
			5'd2: begin
				port = atatfs_pkg::PORT_SECCOUNT_HI;
				data = 8'd0;
			end
			5'd5: begin
				port = atatfs_pkg::PORT_LBA3;
				data = cur_q.b3;
			end
			5'd8: begin
				port = atatfs_pkg::PORT_LBA4;
				data = 8'd0;
			end
			5'd11: begin
				port = atatfs_pkg::PORT_LBA5;
				data = 8'd0;
			end
			5'd13: begin
				port = atatfs_pkg::PORT_SECCOUNT;
				data = cur_q.count;
			end
			5'd14: begin
				port = atatfs_pkg::PORT_LBA0;
				data = cur_q.b0;
			end
			5'd15: begin
				port = atatfs_pkg::PORT_LBA1;
				data = cur_q.b1;
			end
			5'd16: begin
				port = atatfs_pkg::PORT_LBA2;
				data = cur_q.b2;
			end
			default: begin
				port = atatfs_pkg::PORT_COMMAND;
				data = cur_q.cmd;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			irq_q    <= 1'b0;
			cur_v_q  <= 1'b0;
			step_q   <= 5'd0;
			m_tvalid <= 1'b0;
		end else begin
			if (cfg_we) irq_q <= cfg_wdata;
			if (f_ready) cur_v_q <= f_valid;
			if (emit) step_q <= last_beat ? 5'd0 : step_q + 5'd1;
			if (out_free) m_tvalid <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (f_ready) cur_q <= nxt_set;
		if (emit) begin
			m_tdata <= data;
			m_tuser <= {cur_q.mode, port};
			m_tlast <= last_beat;
		end
	end

endmodule
